// ----- sv/sorted_table_insert_delete_search_macros.svh -----
// Assertion macros used by the sorted table top level.
`ifndef SORTED_TABLE_INSERT_DELETE_SEARCH_MACROS_SVH
`define SORTED_TABLE_INSERT_DELETE_SEARCH_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define STI_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define STI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sti_pkg.sv -----
// Package with sizes, codes and shared types of the sorted table.
`default_nettype none
package sti_pkg;

    localparam int DEPTH = 128;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_DELETED  = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
    } cell_ctrl_t;

    // Step result of the binary search unit
    typedef struct packed {
        logic             done;
        logic             found;
        logic [IDX_W-1:0] mid;
    } srch_res_t;

endpackage
`default_nettype wire

// ----- sv/sorted_table_insert_delete_search.sv -----
// Sorted table top level: a chain of compare-and-shift cells plus a search unit.
//
// Usage: one input word (command, value) enters on in_valid while in_stall is low;
// every word gives exactly one result word (status, index, entry_count) on out_valid,
// held until out_stall is low at a clock edge.
// Insert places the value after equal entries, delete drops the first equal entry,
// query binary-searches with a floor midpoint. Insert and delete shift every cell from
// the insert or delete point on at once. A word passes through the compare and decide
// states, then for a query the search state, then the output state. The search unit
// takes one step per cycle and sets the query time. One word is in work at a time:
// in_stall is high from the accepting edge until the result moves to the output
// register, so a new word is taken while the previous result still waits there. If
// the receiver stalls, the next result waits in its last step and the input stays stalled.
// Reset (rst_n, asynchronous) empties the table: the count goes to zero and the
// output register goes invalid; cell contents need no clearing.
`default_nettype none
`include "sorted_table_insert_delete_search_macros.svh"
module sorted_table_insert_delete_search (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_stall,
    input  wire [1:0]                             command,
    input  wire logic signed [sti_pkg::VAL_W-1:0] value,
    output logic                                  out_valid,
    input  wire                                   out_stall,
    output logic [2:0]                            status,
    output logic [6:0]                            index,
    output logic [7:0]                            entry_count
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                        state_reg;
    logic [sti_pkg::CNT_W-1:0]         count_reg;
    logic [1:0]                        cmd_reg;
    logic signed [sti_pkg::VAL_W-1:0]  value_reg;
    logic [2:0]                        res_status_reg;
    logic [sti_pkg::IDX_W-1:0]         res_index_reg;
    logic                              out_valid_reg;
    logic [2:0]                        status_reg;
    logic [6:0]                        index_reg;
    logic [7:0]                        entry_count_reg;

    sti_pkg::cell_ctrl_t               ctrl;
    sti_pkg::srch_res_t                srch;
    logic signed [sti_pkg::VAL_W-1:0]  entry_vec [sti_pkg::DEPTH];
    logic [sti_pkg::DEPTH-1:0]         le_vec;
    logic [sti_pkg::DEPTH-1:0]         eq_vec;
    logic [sti_pkg::DEPTH-1:0]         lt_vec;
    logic [sti_pkg::DEPTH-1:0]         ins_hot;
    logic [sti_pkg::DEPTH-1:0]         del_hot;
    logic [sti_pkg::IDX_W-1:0]         ins_idx;
    logic [sti_pkg::IDX_W-1:0]         del_idx;
    logic                              full;
    logic                              del_any;
    logic                              srch_start;
    logic                              load_out;
    logic [sti_pkg::IDX_W+6:0]         index_wide;
    logic [sti_pkg::CNT_W+7:0]         count_wide;

    // Build the chain of cells
    for (genvar i = 0; i < sti_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [sti_pkg::VAL_W-1:0] left_entry;
        logic signed [sti_pkg::VAL_W-1:0] right_entry;
        logic                             left_le;
        logic                             left_eq;
        logic                             valid;

        if (i == 0)
        begin : g_first
            assign left_entry = value_reg;
            assign left_le    = 1'b1;
            assign left_eq    = 1'b0;
        end
        else
        begin : g_inner
            assign left_entry = entry_vec[i-1];
            assign left_le    = le_vec[i-1];
            assign left_eq    = eq_vec[i-1];
        end

        if (i == sti_pkg::DEPTH - 1)
        begin : g_last
            assign right_entry = entry_vec[i];
        end
        else
        begin : g_mid
            assign right_entry = entry_vec[i+1];
        end

        assign valid = sti_pkg::CNT_W'(i) < count_reg;

        sti_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .value       (value_reg),
            .valid       (valid),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .left_le     (left_le),
            .left_eq     (left_eq),
            .entry       (entry_vec[i]),
            .le          (le_vec[i]),
            .eq          (eq_vec[i]),
            .lt          (lt_vec[i]),
            .ins_hot     (ins_hot[i]),
            .del_hot     (del_hot[i])
        );
    end

    sti_search u_search (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (srch_start),
        .count  (count_reg),
        .lt_vec (lt_vec),
        .eq_vec (eq_vec),
        .res    (srch)
    );

    // Encode the one-hot insert and delete points
    always_comb
    begin
        ins_idx = '0;
        del_idx = '0;
        for (int i = 0; i < sti_pkg::DEPTH; i++)
        begin
            if (ins_hot[i])
            begin
                ins_idx = ins_idx | sti_pkg::IDX_W'(i);
            end
            if (del_hot[i])
            begin
                del_idx = del_idx | sti_pkg::IDX_W'(i);
            end
        end
    end

    // Decode control for cells and search
    always_comb
    begin
        full        = count_reg == sti_pkg::CNT_W'(sti_pkg::DEPTH);
        del_any     = |del_hot;
        ctrl.cmp_en = state_reg == S_CMP;
        ctrl.ins_en = (state_reg == S_DEC) && (cmd_reg == sti_pkg::CMD_INSERT) && !full;
        ctrl.del_en = (state_reg == S_DEC) && (cmd_reg == sti_pkg::CMD_DELETE) && del_any;
        srch_start  = (state_reg == S_DEC) && (cmd_reg == sti_pkg::CMD_QUERY);
        load_out    = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
        index_wide  = (sti_pkg::IDX_W + 7)'(res_index_reg);
        count_wide  = (sti_pkg::CNT_W + 8)'(count_reg);
    end

    // Sequence one word through compare, decide, search and output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    if (ctrl.ins_en)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    else if (ctrl.del_en)
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                    state_reg <= srch_start ? S_SRCH : S_OUT;
                end
                S_SRCH:
                begin
                    if (srch.done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the word and its result
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            cmd_reg   <= command;
            value_reg <= value;
        end

        if (state_reg == S_DEC)
        begin
            case (cmd_reg)
                sti_pkg::CMD_INSERT:
                begin
                    if (full)
                    begin
                        res_status_reg <= sti_pkg::ST_FULL;
                        res_index_reg  <= '0;
                    end
                    else
                    begin
                        res_status_reg <= sti_pkg::ST_INSERTED;
                        res_index_reg  <= ins_idx;
                    end
                end
                sti_pkg::CMD_DELETE:
                begin
                    if (del_any)
                    begin
                        res_status_reg <= sti_pkg::ST_DELETED;
                        res_index_reg  <= del_idx;
                    end
                    else
                    begin
                        res_status_reg <= sti_pkg::ST_MISSING;
                        res_index_reg  <= '0;
                    end
                end
                default:
                begin
                    res_status_reg <= sti_pkg::ST_MISSING;
                    res_index_reg  <= '0;
                end
            endcase
        end
        else if ((state_reg == S_SRCH) && srch.done)
        begin
            res_status_reg <= srch.found ? sti_pkg::ST_FOUND : sti_pkg::ST_MISSING;
            res_index_reg  <= srch.found ? srch.mid : '0;
        end

        if (load_out)
        begin
            status_reg      <= res_status_reg;
            index_reg       <= index_wide[6:0];
            entry_count_reg <= count_wide[7:0];
        end
    end

    assign in_stall    = state_reg != S_IDLE;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign index       = index_reg;
    assign entry_count = entry_count_reg;

    `STI_ASSERT_ALWAYS(a_count_bound, count_reg <= sti_pkg::CNT_W'(sti_pkg::DEPTH), "count above depth")
    `STI_ASSERT_ALWAYS(a_ins_point, (state_reg != S_DEC) || $onehot0(ins_hot), "several insert points")
    `STI_ASSERT_ALWAYS(a_del_point, (state_reg != S_DEC) || $onehot0(del_hot), "several delete points")
    `STI_ASSERT_NEXT(a_ins_count, ctrl.ins_en, count_reg == $past(count_reg) + 1'b1, "insert count step")

endmodule
`default_nettype wire

// ----- sv/sti_cell.sv -----
// One table cell: holds an entry, compares it and shifts with its neighbors.
`default_nettype none
module sti_cell (
    input  wire                              clk,
    input  wire sti_pkg::cell_ctrl_t         ctrl,
    input  wire logic signed [sti_pkg::VAL_W-1:0] value,
    input  wire                              valid,
    input  wire logic signed [sti_pkg::VAL_W-1:0] left_entry,
    input  wire logic signed [sti_pkg::VAL_W-1:0] right_entry,
    input  wire                              left_le,
    input  wire                              left_eq,
    output logic signed [sti_pkg::VAL_W-1:0] entry,
    output logic                             le,
    output logic                             eq,
    output logic                             lt,
    output logic                             ins_hot,
    output logic                             del_hot
);

    logic signed [sti_pkg::VAL_W-1:0] entry_reg;
    logic                             lt_reg;
    logic                             eq_reg;
    logic                             le_reg;
    logic                             ge;

    // Mark insert point, first equal entry and shift region
    always_comb
    begin
        ins_hot = left_le && !le_reg;
        del_hot = eq_reg && !left_eq;
        ge      = lt_reg || eq_reg;
    end

    // Latch compare flags against the current word
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            lt_reg <= value < entry_reg;
            eq_reg <= valid && (value == entry_reg);
            le_reg <= valid && !(value < entry_reg);
        end
    end

    // Load the new value, take from the left on insert, from the right on delete
    always_ff @(posedge clk)
    begin
        if (ctrl.ins_en)
        begin
            if (ins_hot)
            begin
                entry_reg <= value;
            end
            else if (!left_le)
            begin
                entry_reg <= left_entry;
            end
        end
        else if (ctrl.del_en && ge)
        begin
            entry_reg <= right_entry;
        end
    end

    assign entry = entry_reg;
    assign le    = le_reg;
    assign eq    = eq_reg;
    assign lt    = lt_reg;

endmodule
`default_nettype wire

// ----- sv/sti_search.sv -----
// Binary search unit stepping over the compare flags of the cells.
`default_nettype none
module sti_search (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire [sti_pkg::CNT_W-1:0]    count,
    input  wire [sti_pkg::DEPTH-1:0]    lt_vec,
    input  wire [sti_pkg::DEPTH-1:0]    eq_vec,
    output sti_pkg::srch_res_t          res
);

    logic                      busy_reg;
    logic [sti_pkg::CNT_W-1:0] lo_reg;
    logic [sti_pkg::CNT_W-1:0] hix_reg;
    logic [sti_pkg::CNT_W:0]   sum;
    logic                      empty;

    // Take floor midpoint of lo and hi, hi kept as one past the end
    always_comb
    begin
        sum       = (sti_pkg::CNT_W + 1)'(lo_reg) + (sti_pkg::CNT_W + 1)'(hix_reg) - 1'b1;
        res.mid   = sum[sti_pkg::IDX_W:1];
        empty     = lo_reg >= hix_reg;
        res.found = busy_reg && !empty && eq_vec[res.mid];
        res.done  = busy_reg && (empty || eq_vec[res.mid]);
    end

    // Narrow the range one step per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            lo_reg   <= '0;
            hix_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            lo_reg   <= '0;
            hix_reg  <= count;
        end
        else if (busy_reg)
        begin
            if (res.done)
            begin
                busy_reg <= 1'b0;
            end
            else if (lt_vec[res.mid])
            begin
                hix_reg <= sti_pkg::CNT_W'(res.mid);
            end
            else
            begin
                lo_reg <= sti_pkg::CNT_W'(res.mid) + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire
